@@ rtl/core/prp_pkg.sv @@
// ----------------------------------------------------------------------------
// prp_pkg
// shared types, codes and defaults of the page replacement policy core
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int PAGE_W          = 8;
  localparam int TOTAL_W         = 32;
  localparam int POLICY_W        = 3;
  localparam int NFR_W           = 5;
  localparam int CFG_DATA_W      = 5;
  localparam int CFG_IDX_W       = 1;
  localparam int FRAMES_DEFAULT  = 16;
  localparam int COUNT_W_DEFAULT = 16;

  localparam logic [NFR_W-1:0] NUM_FRAMES_RESET = NFR_W'(3);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES = 1'b1;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIFO     = 3'd0,
    POL_LRU      = 3'd1,
    POL_LFU_FIFO = 3'd2,
    POL_MFU_FIFO = 3'd3,
    POL_LFU_LRU  = 3'd4,
    POL_MFU_LRU  = 3'd5
  } policy_t;

  // decoded policy behavior
  typedef struct packed {
    logic counting;
    logic moving;
    logic want_min;
    logic want_max;
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_APPEND,
    ST_FINISH
  } state_t;

  function automatic mode_t decode_policy(logic [POLICY_W-1:0] code);
    mode_t m;
    m = '0;
    case (code)
      POL_LRU: begin
        m.moving = 1'b1;
      end
      POL_LFU_FIFO: begin
        m.counting = 1'b1;
        m.want_min = 1'b1;
      end
      POL_MFU_FIFO: begin
        m.counting = 1'b1;
        m.want_max = 1'b1;
      end
      POL_LFU_LRU: begin
        m.counting = 1'b1;
        m.moving   = 1'b1;
        m.want_min = 1'b1;
      end
      POL_MFU_LRU: begin
        m.counting = 1'b1;
        m.moving   = 1'b1;
        m.want_max = 1'b1;
      end
      default: begin
        m = '0;
      end
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/prp_frame_ram.sv @@
// ----------------------------------------------------------------------------
// prp_frame_ram
// frame store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module prp_frame_ram #(
  parameter int DEPTH = prp_pkg::FRAMES_DEFAULT,
  parameter int AW    = 4,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/prp_scan.sv @@
// ----------------------------------------------------------------------------
// prp_scan
// match search and victim tracking over entries streamed from the store
// ----------------------------------------------------------------------------
module prp_scan #(
  parameter int IW = 4,
  parameter int CW = prp_pkg::COUNT_W_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      eval,
  input  logic [IW-1:0]             idx,
  input  logic [prp_pkg::PAGE_W-1:0] rd_page,
  input  logic [CW-1:0]             rd_cnt,
  input  logic [prp_pkg::PAGE_W-1:0] page,
  input  prp_pkg::mode_t            mode,
  output logic                      hit,
  output logic [IW-1:0]             hit_pos,
  output logic [CW-1:0]             hit_cnt,
  output logic [IW-1:0]             sel_pos,
  output logic [prp_pkg::PAGE_W-1:0] sel_page
);

  logic [CW-1:0] sel_cnt;
  logic          match;
  logic          better;

  assign match  = !hit && (rd_page == page);
  assign better = (idx == '0)
               || (mode.want_min && (rd_cnt < sel_cnt))
               || (mode.want_max && (rd_cnt > sel_cnt));

  always_ff @(posedge clk) begin
    if (rst || start) begin
      hit <= 1'b0;
    end else if (eval && match) begin
      hit <= 1'b1;
    end
  end

  // first match and first extreme count win
  always_ff @(posedge clk) begin
    if (eval && match) begin
      hit_pos <= idx;
      hit_cnt <= rd_cnt;
    end
    if (eval && better) begin
      sel_pos  <= idx;
      sel_cnt  <= rd_cnt;
      sel_page <= rd_page;
    end
  end

endmodule

@@ rtl/core/page_replacement_policy_core.sv @@
// ----------------------------------------------------------------------------
// page_replacement_policy_core
// page reference tracker with FIFO, LRU, LFU and MFU replacement
// ----------------------------------------------------------------------------
// Each request carries one page reference, checked against an ordered store
// of resident pages (oldest first) held in a single-port-read, single-port-
// write memory together with per-page use counts. The block works on one
// request at a time. A request streams the store past the match and victim
// logic and decides; then, when an entry is removed (LRU move or eviction),
// it compacts the store one entry per cycle through the memory port, writes
// the new entry and posts the result once the output register is free, and
// passes through idle before the next request is taken. The next request is
// taken while a result still waits at the output register. Configuration is
// to be written through cfg_en/cfg_index/cfg_data only while the block is
// idle; the block itself does not enforce this. Unused policy codes behave
// as FIFO and num_frames is clamped to 1..FRAMES.
// ----------------------------------------------------------------------------
module page_replacement_policy_core #(
  parameter int FRAMES  = prp_pkg::FRAMES_DEFAULT,
  parameter int COUNT_W = prp_pkg::COUNT_W_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          cfg_en,
  input  logic [prp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prp_pkg::CFG_DATA_W-1:0] cfg_data,
  // reference request
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [prp_pkg::PAGE_W-1:0]     page,
  // result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          fault,
  output logic                          replaced,
  output logic [prp_pkg::PAGE_W-1:0]     victim_page,
  output logic [prp_pkg::TOTAL_W-1:0]    fault_total,
  output logic [prp_pkg::TOTAL_W-1:0]    replace_total
);

  // index, occupancy, limit and data widths
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OW = $clog2(FRAMES + 1);
  localparam int LW = (OW > prp_pkg::NFR_W) ? OW : prp_pkg::NFR_W;
  localparam int DW = prp_pkg::PAGE_W + COUNT_W;

  // configuration registers
  logic [prp_pkg::POLICY_W-1:0] policy;
  logic [prp_pkg::NFR_W-1:0]    num_frames;

  // control state
  prp_pkg::state_t state, state_next;
  logic [OW-1:0]   occ;
  logic [OW-1:0]   issue_idx;
  logic            pend;
  logic [OW-1:0]   pend_idx;

  // per-request payload
  logic [prp_pkg::PAGE_W-1:0] page_reg;
  prp_pkg::mode_t             mode;
  logic [IW-1:0]              fin_addr;
  logic [DW-1:0]              fin_data;
  logic                       res_fault;
  logic                       res_repl;
  logic [prp_pkg::PAGE_W-1:0] res_victim;

  // memory port
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;
  logic [OW-1:0] shift_dst;

  // scan results
  logic                       hit;
  logic [IW-1:0]              hit_pos;
  logic [COUNT_W-1:0]         hit_cnt;
  logic [IW-1:0]              sel_pos;
  logic [prp_pkg::PAGE_W-1:0] sel_page;

  // decision terms
  logic [LW-1:0]      limit;
  logic [LW-1:0]      nf_ext;
  logic               full;
  logic [COUNT_W-1:0] new_cnt;
  logic               accept;
  logic               scan_done;
  logic               out_free;

  assign accept    = in_valid && in_ready;
  assign scan_done = (issue_idx == occ) && !pend;
  assign out_free  = !out_valid || out_ready;

  // clamp the frame limit to 1..FRAMES
  assign nf_ext = LW'(num_frames);
  always_comb begin
    if (nf_ext == '0) begin
      limit = LW'(1);
    end else if (nf_ext > LW'(FRAMES)) begin
      limit = LW'(FRAMES);
    end else begin
      limit = nf_ext;
    end
  end

  assign full    = LW'(occ) >= limit;
  assign new_cnt = (mode.counting && (hit_cnt != '1)) ? hit_cnt + COUNT_W'(1) : hit_cnt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= prp_pkg::POL_FIFO;
      num_frames <= prp_pkg::NUM_FRAMES_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        prp_pkg::CFG_POLICY: begin
          policy <= cfg_data[prp_pkg::POLICY_W-1:0];
        end
        prp_pkg::CFG_NUM_FRAMES: begin
          num_frames <= cfg_data[prp_pkg::NFR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      prp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = prp_pkg::ST_SCAN;
        end
      end
      prp_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = prp_pkg::ST_DECIDE;
        end
      end
      prp_pkg::ST_DECIDE: begin
        // a removal (lru move or eviction) needs compaction first
        if ((hit && mode.moving) || (!hit && full)) begin
          state_next = prp_pkg::ST_SHIFT;
        end else begin
          state_next = prp_pkg::ST_APPEND;
        end
      end
      prp_pkg::ST_SHIFT: begin
        if (scan_done) begin
          state_next = prp_pkg::ST_APPEND;
        end
      end
      prp_pkg::ST_APPEND: begin
        state_next = prp_pkg::ST_FINISH;
      end
      prp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = prp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = prp_pkg::ST_IDLE;
      end
    endcase
  end

  // read sequencing: one entry per cycle, data back in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      pend      <= 1'b0;
    end else begin
      case (state)
        prp_pkg::ST_IDLE: begin
          issue_idx <= '0;
          pend      <= 1'b0;
        end
        prp_pkg::ST_SCAN, prp_pkg::ST_SHIFT: begin
          if (issue_idx < occ) begin
            pend      <= 1'b1;
            issue_idx <= issue_idx + OW'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        prp_pkg::ST_DECIDE: begin
          pend <= 1'b0;
          // compaction starts one past the removed entry
          if (hit) begin
            issue_idx <= OW'(hit_pos) + OW'(1);
          end else begin
            issue_idx <= OW'(sel_pos) + OW'(1);
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= issue_idx;
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if ((state == prp_pkg::ST_DECIDE) && !hit && !full) begin
      occ <= occ + OW'(1);
    end
  end

  // request payload and decision
  always_ff @(posedge clk) begin
    if (accept) begin
      page_reg   <= page;
      mode       <= prp_pkg::decode_policy(policy);
      res_fault  <= 1'b0;
      res_repl   <= 1'b0;
      res_victim <= '0;
    end
    if (state == prp_pkg::ST_DECIDE) begin
      if (hit) begin
        fin_data <= {page_reg, new_cnt};
        fin_addr <= mode.moving ? IW'(occ - OW'(1)) : hit_pos;
      end else begin
        res_fault <= 1'b1;
        fin_data  <= {page_reg, {COUNT_W{1'b0}}};
        if (full) begin
          res_repl   <= 1'b1;
          res_victim <= sel_page;
          fin_addr   <= IW'(occ - OW'(1));
        end else begin
          fin_addr <= occ[IW-1:0];
        end
      end
    end
  end

  // memory writes: compaction moves entry i+1 to i, then the new entry lands
  assign shift_dst = pend_idx - OW'(1);
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fin_addr;
    ram_wdata = fin_data;
    if ((state == prp_pkg::ST_SHIFT) && pend) begin
      ram_we    = 1'b1;
      ram_waddr = shift_dst[IW-1:0];
      ram_wdata = ram_rdata;
    end else if (state == prp_pkg::ST_APPEND) begin
      ram_we = 1'b1;
    end
  end

  prp_frame_ram #(
    .DEPTH (FRAMES),
    .AW    (IW),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  prp_scan #(
    .IW (IW),
    .CW (COUNT_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .eval     ((state == prp_pkg::ST_SCAN) && pend),
    .idx      (pend_idx[IW-1:0]),
    .rd_page  (ram_rdata[DW-1 -: prp_pkg::PAGE_W]),
    .rd_cnt   (ram_rdata[COUNT_W-1:0]),
    .page     (page_reg),
    .mode     (mode),
    .hit      (hit),
    .hit_pos  (hit_pos),
    .hit_cnt  (hit_cnt),
    .sel_pos  (sel_pos),
    .sel_page (sel_page)
  );

  // result register and saturating totals
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      fault_total   <= '0;
      replace_total <= '0;
    end else if ((state == prp_pkg::ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
      if (res_fault && (fault_total != '1)) begin
        fault_total <= fault_total + prp_pkg::TOTAL_W'(1);
      end
      if (res_repl && (replace_total != '1)) begin
        replace_total <= replace_total + prp_pkg::TOTAL_W'(1);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == prp_pkg::ST_FINISH) && out_free) begin
      fault       <= res_fault;
      replaced    <= res_repl;
      victim_page <= res_victim;
    end
  end

  // the store never holds more than FRAMES pages
  assert property (@(posedge clk) disable iff (rst) occ <= OW'(FRAMES))
    else $error("occupancy above frame count");

  // an accepted request always starts a scan of the store
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == prp_pkg::ST_SCAN) && (issue_idx == '0))
    else $error("request not followed by scan");

  // an eviction only comes with a fault
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!replaced || fault))
    else $error("replacement without fault");

  // no victim reported without a replacement
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !replaced) |-> (victim_page == '0))
    else $error("victim page set without replacement");

endmodule

@@ verif/tb_page_replacement_policy_core.sv @@
// ----------------------------------------------------------------------------
// tb_page_replacement_policy_core
// self-checking regression of the page replacement policy core
// ----------------------------------------------------------------------------
// Page references go in over a valid/ready request channel. An in-bench
// model of the ordered frame store tracks resident pages, their use counts
// and the fault and replacement totals, and queues one expected result per
// accepted request. A checker pops that queue on every accepted result. The
// run has directed tests for reset defaults, count saturation, every policy
// code and frame-count clamping, then random phases that each reprogram the
// block and stream references drawn mostly from a small page pool, so hits,
// misses and evictions all occur. Both sides idle at random, and the result
// side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_page_replacement_policy_core;
  import prp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES      = FRAMES_DEFAULT;
  localparam int COUNT_W     = 4;     // narrow counts saturate after a few hits
  localparam int STALL_LIMIT = 2000;  // cycles with no request or result moving
  localparam int HOLD_CYCLES = 300;   // long back-pressure stretch on results
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES      = 30;
  localparam int PHASE_REFS  = 60;

  // last policy code, unnamed in the package, decodes as FIFO
  localparam logic [POLICY_W-1:0] POL_UNUSED_B = 3'd7;

  typedef struct {
    logic                 fault;
    logic                 replaced;
    logic [PAGE_W-1:0]    victim;
    logic [TOTAL_W-1:0]   faults;
    logic [TOTAL_W-1:0]   evictions;
  } page_outcome_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_POLICY;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PAGE_W-1:0]      page = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   fault;
  logic                   replaced;
  logic [PAGE_W-1:0]      victim_page;
  logic [TOTAL_W-1:0]     fault_total;
  logic [TOTAL_W-1:0]     replace_total;

  // shadow of the frame store and the programmed registers
  logic [PAGE_W-1:0]      resident_page [FRAMES];
  logic [COUNT_W-1:0]     use_count [FRAMES];
  int unsigned            resident_n = 0;
  logic [TOTAL_W-1:0]     faults_seen = '0;
  logic [TOTAL_W-1:0]     evictions_seen = '0;
  logic [POLICY_W-1:0]    policy_cfg = POL_FIFO;
  logic [NFR_W-1:0]       frames_cfg = NUM_FRAMES_RESET;

  page_outcome_t          pending_outcomes [$];
  int                     error_count = 0;
  int                     results_checked = 0;
  int                     requests_sent = 0;
  int                     idle_pct = 16;
  logic                   hold_active = 1'b0;
  event                   start_hold;

  page_replacement_policy_core #(
    .FRAMES  (FRAMES),
    .COUNT_W (COUNT_W)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_en        (cfg_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page          (page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fault         (fault),
    .replaced      (replaced),
    .victim_page   (victim_page),
    .fault_total   (fault_total),
    .replace_total (replace_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // frame store model
  // ------------------------------------------------------------------------

  // close the gap left by the entry at pos, younger entries move one down
  function automatic void drop_entry(input int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < resident_n; i++) begin
      resident_page[i] = resident_page[i + 1];
      use_count[i]     = use_count[i + 1];
    end
    resident_n--;
  endfunction

  // apply one reference to the shadow store and queue the result it causes
  function automatic void predict_reference(input logic [PAGE_W-1:0] pg);
    policy_t            pol;
    logic               counting;
    logic               moving;
    logic               want_min;
    logic               want_max;
    int unsigned        limit;
    int unsigned        pos;
    int unsigned        sel;
    int unsigned        i;
    logic               hit;
    logic [COUNT_W-1:0] cnt;
    page_outcome_t      r;

    // codes past the last named policy fall back to FIFO
    pol      = (policy_cfg > POL_MFU_LRU) ? POL_FIFO : policy_t'(policy_cfg);
    counting = (pol != POL_FIFO) && (pol != POL_LRU);
    moving   = (pol == POL_LRU) || (pol == POL_LFU_LRU) || (pol == POL_MFU_LRU);
    want_min = (pol == POL_LFU_FIFO) || (pol == POL_LFU_LRU);
    want_max = (pol == POL_MFU_FIFO) || (pol == POL_MFU_LRU);

    limit = frames_cfg;
    if (limit < 1) limit = 1;
    if (limit > FRAMES) limit = FRAMES;

    r   = '{fault: 1'b0, replaced: 1'b0, victim: '0, faults: '0, evictions: '0};
    hit = 1'b0;
    pos = 0;
    for (i = 0; i < resident_n; i++) begin
      if (!hit && resident_page[i] == pg) begin
        pos = i;
        hit = 1'b1;
      end
    end

    if (hit) begin
      cnt = use_count[pos];
      if (counting && cnt != {COUNT_W{1'b1}}) cnt++;
      use_count[pos] = cnt;
      // LRU-style modes move the page to the newest end
      if (moving) begin
        drop_entry(pos);
        resident_page[resident_n] = pg;
        use_count[resident_n]     = cnt;
        resident_n++;
      end
    end else begin
      r.fault = 1'b1;
      if (faults_seen != {TOTAL_W{1'b1}}) faults_seen++;
      // store at or over the limit: one victim goes, even if the limit was
      // lowered below the current occupancy
      if (resident_n >= limit && resident_n > 0) begin
        r.replaced = 1'b1;
        if (evictions_seen != {TOTAL_W{1'b1}}) evictions_seen++;
        sel = 0;
        // strict compares, so ties go to the oldest entry
        for (i = 1; i < resident_n; i++) begin
          if (want_min && use_count[i] < use_count[sel]) sel = i;
          if (want_max && use_count[i] > use_count[sel]) sel = i;
        end
        r.victim = resident_page[sel];
        drop_entry(sel);
      end
      if (resident_n < FRAMES) begin
        resident_page[resident_n] = pg;
        use_count[resident_n]     = '0;
        resident_n++;
      end
    end

    r.faults    = faults_seen;
    r.evictions = evictions_seen;
    pending_outcomes = {pending_outcomes, r};
  endfunction

  // ------------------------------------------------------------------------
  // shared stimulus tasks
  // ------------------------------------------------------------------------

  // offer one page reference, with a random gap in front of it
  task automatic send_reference(input logic [PAGE_W-1:0] pg);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    page     <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_reference(pg);
    requests_sent++;
  endtask

  // stop offering requests until every queued result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // program both registers once the block has gone idle
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] policy_data,
                                input logic [CFG_DATA_W-1:0] frames_data);
    wait_drained();
    cfg_en    <= 1'b1;
    cfg_index <= CFG_POLICY;
    cfg_data  <= policy_data;
    @(posedge clk);
    policy_cfg = policy_data[POLICY_W-1:0];
    cfg_index <= CFG_NUM_FRAMES;
    cfg_data  <= frames_data;
    @(posedge clk);
    frames_cfg = frames_data;
    cfg_en    <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // result side: ready pattern, long hold-off and checking
  // ------------------------------------------------------------------------

  initial begin
    forever begin
      @(start_hold);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    page_outcome_t head;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: fault %0b replaced %0b victim %02h",
                   fault, replaced, victim_page);
      end else begin
        head = pending_outcomes.pop_front();
        results_checked++;
        if (fault !== head.fault || replaced !== head.replaced ||
            victim_page !== head.victim || fault_total !== head.faults ||
            replace_total !== head.evictions) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result %0d mismatch: expected f%0b r%0b v%02h ft%0d rt%0d",
                     results_checked, head.fault, head.replaced, head.victim,
                     head.faults, head.evictions);
            $display("  got f%0b r%0b v%02h ft%0d rt%0d",
                     fault, replaced, victim_page, fault_total, replace_total);
          end
        end
      end
    end
    out_ready <= !hold_active && ($urandom_range(0, 99) >= idle_pct);
  end

  // ends the run when neither channel has moved for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no request or result moved in %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset values: FIFO with three frames, page extremes, one hit
  task automatic test_reset_defaults();
    send_reference(8'h00);
    send_reference(8'hFF);
    send_reference(8'h00);
    send_reference(8'hA5);
    send_reference(8'h5A);
  endtask

  // one page is hit past the top of its use count, which must stick at
  // all-ones: LFU then evicts a barely used page, MFU the saturated one
  task automatic test_count_saturation();
    int n;
    apply_settings(CFG_DATA_W'(POL_LFU_FIFO), NFR_W'(3));
    idle_pct <= 0;
    for (n = 0; n < (1 << COUNT_W); n++) send_reference(8'hFF);
    send_reference(8'hA5);
    send_reference(8'h5A);
    send_reference(8'h3C);
    apply_settings(CFG_DATA_W'(POL_MFU_FIFO), NFR_W'(3));
    send_reference(8'hC3);
    idle_pct <= 16;
  endtask

  // every policy code but FIFO, with junk in the upper data bits; the frame count
  // drops to two while three pages are resident
  task automatic test_policy_codes();
    logic [PAGE_W-1:0]   pool [4];
    logic [POLICY_W-1:0] code;
    pool = '{8'h11, 8'h22, 8'h33, 8'h44};
    code = POL_LRU;
    forever begin
      apply_settings({2'($urandom), code}, NFR_W'(2));
      send_reference(pool[code % 4]);
      send_reference(pool[(code + 1) % 4]);
      if (code == POL_UNUSED_B) break;
      code++;
    end
  endtask

  // frame counts outside 1..FRAMES are clamped
  task automatic test_frame_clamp();
    apply_settings(CFG_DATA_W'(POL_LRU), NFR_W'(0));
    send_reference(8'h80);
    send_reference(8'h7F);
    apply_settings(CFG_DATA_W'(POL_FIFO), NFR_W'(31));
    send_reference(8'h01);
    send_reference(8'hFE);
    send_reference(8'h80);
  endtask

  // random phases: new settings each time, references mostly from a pool a
  // little larger than the frame count so hits and evictions mix
  task automatic test_random_mix();
    int                  phase;
    int                  k;
    int unsigned         span;
    logic [POLICY_W-1:0] code;
    logic [NFR_W-1:0]    nfr;
    logic [PAGE_W-1:0]   base;
    for (phase = 0; phase < PHASES; phase++) begin
      code = (phase < 8) ? POLICY_W'(phase) : POLICY_W'($urandom_range(0, 7));
      case (phase)
        1, 5:    nfr = NFR_W'(FRAMES);
        2:       nfr = NFR_W'(1);
        3:       nfr = NFR_W'(0);
        4:       nfr = NFR_W'(31);
        default: nfr = ($urandom_range(0, 9) == 0) ? NFR_W'($urandom_range(0, 31))
                                                   : NFR_W'($urandom_range(1, FRAMES));
      endcase
      apply_settings({2'($urandom), code}, nfr);
      // a stretch of phases with no idling on either side
      idle_pct <= (phase >= 20 && phase < 24) ? 0 : 16;
      // the result side stalls while requests keep coming
      if (phase == 10) -> start_hold;
      span = (nfr == 0) ? 1 : (nfr > FRAMES) ? FRAMES : nfr;
      span = span + $urandom_range(0, 3);
      base = PAGE_W'($urandom);
      for (k = 0; k < PHASE_REFS; k++) begin
        if ($urandom_range(0, 9) == 0) send_reference(PAGE_W'($urandom));
        else send_reference(base + PAGE_W'($urandom_range(0, span - 1)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_count_saturation();
    test_policy_codes();
    test_frame_clamp();
    test_random_mix();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests over all policy codes, frame counts 0..31, saturation",
             requests_sent);
    $display("%0d results checked, %0d faults and %0d replacements, %0d errors",
             results_checked, faults_seen, evictions_seen, error_count);
    if (error_count == 0 && pending_outcomes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/prp_pkg.sv
rtl/core/prp_frame_ram.sv
rtl/core/prp_scan.sv
rtl/core/page_replacement_policy_core.sv
verif/tb_page_replacement_policy_core.sv
